// ===== rtl/value_noise_2d_sampler_defines.svh =====
// Assertion macros for the value noise sampler.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef VALUE_NOISE_2D_SAMPLER_DEFINES_SVH
`define VALUE_NOISE_2D_SAMPLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VN2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define VN2D_ASSERT_IN_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define VN2D_ASSERT(lbl, prop, msg)
`define VN2D_ASSERT_IN_RESET(lbl, prop, msg)
`endif

`endif

// ===== rtl/vn2d_pkg.sv =====
// Shared constants, types and helper functions of the value noise sampler.
// Used by every module of the block; depends on nothing.
package vn2d_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned FracShr  = (FracBits >= 16) ? FracBits - 16 : 0;
  localparam int unsigned FracShl  = (FracBits < 16) ? 16 - FracBits : 0;

  localparam int unsigned NumStages  = 13;
  localparam int unsigned StSeed     = 0;
  localparam int unsigned StPre1     = 1;
  localparam int unsigned StMix1     = 2;
  localparam int unsigned StPre2     = 3;
  localparam int unsigned StMix2     = 4;
  localparam int unsigned StMul1     = 5;
  localparam int unsigned StSum1     = 6;
  localparam int unsigned StMul2     = 7;
  localparam int unsigned StSum2     = 8;
  localparam int unsigned StLerpXMul = 9;
  localparam int unsigned StLerpXSum = 10;
  localparam int unsigned StLerpZMul = 11;
  localparam int unsigned StOut      = 12;

  localparam logic [63:0] GoldenK   = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MixK1     = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MixK2     = 64'h94d0_49bb_1331_11eb;
  localparam logic [17:0] FadeThree = 18'd196608;
  localparam logic [16:0] LerpOne   = 17'h1_0000;

  typedef logic [NumStages-1:0] stage_en_t;
  typedef logic [15:0]          q16_t;

  function automatic q16_t frac_q16(logic [31:0] v);
    logic [47:0] f;
    f = {16'b0, v} & ((48'd1 << FracBits) - 48'd1);
    f = (f >> FracShr) << FracShl;
    return f[15:0];
  endfunction

  function automatic logic [63:0] floor_lat(logic [31:0] v);
    logic signed [63:0] w;
    w = $signed({{32{v[31]}}, v});
    return 64'(w >>> FracBits);
  endfunction

  function automatic logic [63:0] mix_pre(logic [63:0] h);
    return GoldenK + (h << 6) + (h >> 2);
  endfunction

endpackage

// ===== rtl/vn2d_intf.sv =====
// Handshake channels of the value noise sampler: sample words in, noise words out.
// Depends on nothing.
interface vn2d_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] z_coord;
  logic [7:0]         seed_offset;

  modport source(output valid, x_coord, z_coord, seed_offset, input ready);
  modport sink(input valid, x_coord, z_coord, seed_offset, output ready);
endinterface

interface vn2d_noise_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;

  modport source(output valid, noise_value, input ready);
  modport sink(input valid, noise_value, output ready);
endinterface

// ===== rtl/vn2d_lattice.sv =====
// Front stages: lattice corners, seed sum, fade curves and the two seed mixing rounds.
// Depends on vn2d_pkg; produces the four pre-finalization corner hashes.
module vn2d_lattice (
  input  logic                    clk_i,
  input  vn2d_pkg::stage_en_t     en_i,
  input  logic [63:0]             base_seed_i,
  input  logic [31:0]             x_coord_i,
  input  logic [31:0]             z_coord_i,
  input  logic [7:0]              seed_offset_i,
  output logic [3:0][63:0]        h2_o,
  output vn2d_pkg::q16_t          sx_o,
  output vn2d_pkg::q16_t          sz_o
);

  logic [63:0]          seed0_q, seed1_q;
  logic [1:0][63:0]     cx0_q, cx1_q, cz0_q, cz1_q, cz2_q, cz3_q;
  logic [63:0]          pre1_q;
  logic [1:0][63:0]     h1_q, h1p_q, pre2_q;
  logic [3:0][63:0]     h2_q;
  vn2d_pkg::q16_t       tx0_q, tz0_q, tx1_q, tz1_q;
  logic [31:0]          ttx_q, ttz_q;
  logic [33:0]          ftx_q, ftz_q;
  vn2d_pkg::q16_t       sx3_q, sz3_q, sx4_q, sz4_q;
  logic [63:0]          ixw, izw;
  logic [17:0]          kx, kz;

  assign ixw = vn2d_pkg::floor_lat(x_coord_i);
  assign izw = vn2d_pkg::floor_lat(z_coord_i);
  assign kx  = vn2d_pkg::FadeThree - {1'b0, tx1_q, 1'b0};
  assign kz  = vn2d_pkg::FadeThree - {1'b0, tz1_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i[vn2d_pkg::StSeed]) begin
      seed0_q  <= base_seed_i + {56'b0, seed_offset_i};
      cx0_q[0] <= ixw;
      cx0_q[1] <= ixw + 64'd1;
      cz0_q[0] <= izw;
      cz0_q[1] <= izw + 64'd1;
      tx0_q    <= vn2d_pkg::frac_q16(x_coord_i);
      tz0_q    <= vn2d_pkg::frac_q16(z_coord_i);
    end
    if (en_i[vn2d_pkg::StPre1]) begin
      seed1_q <= seed0_q;
      pre1_q  <= vn2d_pkg::mix_pre(seed0_q);
      cx1_q   <= cx0_q;
      cz1_q   <= cz0_q;
      tx1_q   <= tx0_q;
      tz1_q   <= tz0_q;
      ttx_q   <= 32'(tx0_q) * 32'(tx0_q);
      ttz_q   <= 32'(tz0_q) * 32'(tz0_q);
    end
    if (en_i[vn2d_pkg::StMix1]) begin
      for (int j = 0; j < 2; j++) begin
        h1_q[j] <= seed1_q ^ (cx1_q[j] + pre1_q);
      end
      cz2_q <= cz1_q;
      ftx_q <= 34'(ttx_q[31:16]) * 34'(kx);
      ftz_q <= 34'(ttz_q[31:16]) * 34'(kz);
    end
    if (en_i[vn2d_pkg::StPre2]) begin
      for (int j = 0; j < 2; j++) begin
        pre2_q[j] <= vn2d_pkg::mix_pre(h1_q[j]);
      end
      h1p_q <= h1_q;
      cz3_q <= cz2_q;
      sx3_q <= (ftx_q[33:32] != 2'b00) ? 16'hffff : ftx_q[31:16];
      sz3_q <= (ftz_q[33:32] != 2'b00) ? 16'hffff : ftz_q[31:16];
    end
    if (en_i[vn2d_pkg::StMix2]) begin
      for (int dz = 0; dz < 2; dz++) begin
        for (int dx = 0; dx < 2; dx++) begin
          h2_q[2*dz+dx] <= h1p_q[dx] ^ (cz3_q[dz] + pre2_q[dx]);
        end
      end
      sx4_q <= sx3_q;
      sz4_q <= sz3_q;
    end
  end

  assign h2_o = h2_q;
  assign sx_o = sx4_q;
  assign sz_o = sz4_q;

endmodule

// ===== rtl/vn2d_hash_tail.sv =====
// Finalizer of one corner hash: two 64-bit constant multiplies split into 32-bit partials.
// Depends on vn2d_pkg; yields the Q0.16 corner value.
module vn2d_hash_tail (
  input  logic                clk_i,
  input  vn2d_pkg::stage_en_t en_i,
  input  logic [63:0]         h2_i,
  output vn2d_pkg::q16_t      corner_o
);

  logic [63:0]    m1, m2, p1, p2, h3;
  logic [63:0]    pa1, pb1, pc1, pa2, pb2, pc2;
  logic [63:0]    pa1_q, pa2_q, p1_q;
  logic [31:0]    pb1_q, pc1_q, pb2_q, pc2_q;
  vn2d_pkg::q16_t corner_q;

  assign m1  = h2_i ^ (h2_i >> 30);
  assign pa1 = 64'(m1[31:0]) * 64'(vn2d_pkg::MixK1[31:0]);
  assign pb1 = 64'(m1[31:0]) * 64'(vn2d_pkg::MixK1[63:32]);
  assign pc1 = 64'(m1[63:32]) * 64'(vn2d_pkg::MixK1[31:0]);
  assign p1  = pa1_q + {pb1_q + pc1_q, 32'b0};

  assign m2  = p1_q ^ (p1_q >> 27);
  assign pa2 = 64'(m2[31:0]) * 64'(vn2d_pkg::MixK2[31:0]);
  assign pb2 = 64'(m2[31:0]) * 64'(vn2d_pkg::MixK2[63:32]);
  assign pc2 = 64'(m2[63:32]) * 64'(vn2d_pkg::MixK2[31:0]);
  assign p2  = pa2_q + {pb2_q + pc2_q, 32'b0};
  assign h3  = p2 ^ (p2 >> 31);

  always_ff @(posedge clk_i) begin
    if (en_i[vn2d_pkg::StMul1]) begin
      pa1_q <= pa1;
      pb1_q <= pb1[31:0];
      pc1_q <= pc1[31:0];
    end
    if (en_i[vn2d_pkg::StSum1]) begin
      p1_q <= p1;
    end
    if (en_i[vn2d_pkg::StMul2]) begin
      pa2_q <= pa2;
      pb2_q <= pb2[31:0];
      pc2_q <= pc2[31:0];
    end
    if (en_i[vn2d_pkg::StSum2]) begin
      corner_q <= h3[31:16];
    end
  end

  assign corner_o = corner_q;

endmodule

// ===== rtl/vn2d_blend.sv =====
// Bilinear blend of the four corner values, along x and then along z.
// Depends on vn2d_pkg; carries the fade weights alongside the hash stages.
module vn2d_blend (
  input  logic                   clk_i,
  input  vn2d_pkg::stage_en_t    en_i,
  input  logic [3:0][15:0]       corner_i,
  input  vn2d_pkg::q16_t         sx_i,
  input  vn2d_pkg::q16_t         sz_i,
  output vn2d_pkg::q16_t         noise_o
);

  logic [3:0][15:0] sx_dly_q, sz_dly_q;
  logic [3:0][31:0] px_q;
  logic [1:0][31:0] pz_q;
  logic [1:0][15:0] ab_q;
  vn2d_pkg::q16_t   szx_q, szs_q, noise_q;
  logic [16:0]      wx, wz;
  logic [31:0]      suma, sumb, sumz;

  assign wx   = vn2d_pkg::LerpOne - {1'b0, sx_dly_q[3]};
  assign wz   = vn2d_pkg::LerpOne - {1'b0, szx_q};
  assign suma = px_q[0] + px_q[1];
  assign sumb = px_q[2] + px_q[3];
  assign sumz = pz_q[0] + pz_q[1];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (en_i[vn2d_pkg::StMul1 + k]) begin
        sx_dly_q[k] <= (k == 0) ? sx_i : sx_dly_q[(k == 0) ? 0 : k - 1];
        sz_dly_q[k] <= (k == 0) ? sz_i : sz_dly_q[(k == 0) ? 0 : k - 1];
      end
    end
    if (en_i[vn2d_pkg::StLerpXMul]) begin
      px_q[0] <= 32'(corner_i[0]) * 32'(wx);
      px_q[1] <= 32'(corner_i[1]) * 32'(sx_dly_q[3]);
      px_q[2] <= 32'(corner_i[2]) * 32'(wx);
      px_q[3] <= 32'(corner_i[3]) * 32'(sx_dly_q[3]);
      szx_q   <= sz_dly_q[3];
    end
    if (en_i[vn2d_pkg::StLerpXSum]) begin
      ab_q[0] <= suma[31:16];
      ab_q[1] <= sumb[31:16];
      szs_q   <= szx_q;
    end
    if (en_i[vn2d_pkg::StLerpZMul]) begin
      pz_q[0] <= 32'(ab_q[0]) * 32'(vn2d_pkg::LerpOne - {1'b0, szs_q});
      pz_q[1] <= 32'(ab_q[1]) * 32'(szs_q);
    end
    if (en_i[vn2d_pkg::StOut]) begin
      noise_q <= sumz[31:16];
    end
  end

  assign noise_o = noise_q;

endmodule

// ===== rtl/value_noise_2d_sampler.sv =====
// Value noise sampler: pipelined from an accepted sample word to its noise word.
// Throughput one word per cycle unless the output stalls; the 64-bit hash multiplies run as 32-bit partial products.
// A stalled output holds its word while empty stages upstream keep filling.
// Reset clears every stage valid bit and sets base_seed to zero.
// Depends on vn2d_pkg, the channel interfaces and the assertion macro header.
`include "value_noise_2d_sampler_defines.svh"

module value_noise_2d_sampler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [63:0]         cfg_wdata_i,
  vn2d_sample_if.sink         sample_i,
  vn2d_noise_if.source        noise_o
);

  localparam int unsigned Last = vn2d_pkg::NumStages - 1;

  logic [63:0]                       base_seed_q;
  logic [vn2d_pkg::NumStages-1:0]    v_q, v_d;
  logic [vn2d_pkg::NumStages:0]      rdy;
  vn2d_pkg::stage_en_t               en;
  logic [3:0][63:0]                  h2;
  logic [3:0][15:0]                  corner;
  vn2d_pkg::q16_t                    sx, sz, noise;
  logic                              in_acc, out_acc;

  always_comb begin
    rdy[vn2d_pkg::NumStages] = noise_o.ready;
    for (int i = Last; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
    v_d[0] = sample_i.valid;
    for (int i = 1; i < vn2d_pkg::NumStages; i++) begin
      v_d[i] = v_q[i-1];
    end
  end

  assign en = rdy[vn2d_pkg::NumStages-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      base_seed_q <= '0;
    end else begin
      for (int i = 0; i < vn2d_pkg::NumStages; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_d[i];
        end
      end
      if (cfg_we_i) begin
        base_seed_q <= cfg_wdata_i;
      end
    end
  end

  vn2d_lattice u_lattice (
    .clk_i         (clk_i),
    .en_i          (en),
    .base_seed_i   (base_seed_q),
    .x_coord_i     (sample_i.x_coord),
    .z_coord_i     (sample_i.z_coord),
    .seed_offset_i (sample_i.seed_offset),
    .h2_o          (h2),
    .sx_o          (sx),
    .sz_o          (sz)
  );

  for (genvar c = 0; c < 4; c++) begin : g_corner
    vn2d_hash_tail u_tail (
      .clk_i    (clk_i),
      .en_i     (en),
      .h2_i     (h2[c]),
      .corner_o (corner[c])
    );
  end

  vn2d_blend u_blend (
    .clk_i    (clk_i),
    .en_i     (en),
    .corner_i (corner),
    .sx_i     (sx),
    .sz_i     (sz),
    .noise_o  (noise)
  );

  assign sample_i.ready      = rdy[0];
  assign noise_o.valid       = v_q[Last];
  assign noise_o.noise_value = noise;

  assign in_acc  = sample_i.valid && rdy[0];
  assign out_acc = v_q[Last] && noise_o.ready;

  `VN2D_ASSERT_IN_RESET(a_empty_in_reset, !rst_ni |-> (v_q == '0), "valid bits set in reset")
  `VN2D_ASSERT(a_words_conserved, $past(rst_ni) |-> ($countones(v_q) == $past($countones(v_q)) + $past(in_acc) - $past(out_acc)), "word lost or duplicated in pipeline")
  `VN2D_ASSERT(a_stall_only_when_full, !rdy[0] |-> (&v_q), "input stalled with a free stage")

endmodule
